// ===== rtl/sss_pkg.sv =====
// Shared types, constants and helper functions for the sample set statistics block.
package sss_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int MAX_SAMPLES_DEF = 256;
  localparam int DIVIDEND_W      = 64;
  localparam int ROOT_IN_W       = 64;
  localparam int ROOT_OUT_W      = 32;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    last;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] median_value;
    logic signed [23:0] mean_value;
    logic signed [31:0] total;
    logic        [23:0] std_dev;
    logic signed [23:0] lower_quartile;
    logic signed [23:0] upper_quartile;
    logic        [8:0]  sample_count;
    logic               std_dev_valid;
    logic               overflowed;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  // Clamp to 24-bit signed.
  function automatic logic [23:0] sat_s24(input longint v);
    logic [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  // Clamp to 32-bit signed.
  function automatic logic [31:0] sat_s32(input longint v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Mean of two samples, rounded half away from zero.
  function automatic longint avg_half(input longint a, input longint b);
    longint s;
    longint r;
    s = a + b;
    if (s >= 0) begin
      r = (s + 1) >>> 1;
    end else begin
      r = -((-s + 1) >>> 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/sample_set_statistics.sv =====
// Top level: sorting chain of cells plus sequencer for the set statistics.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_item_t  (sample, last)
//   out     | output    | out_valid/out_stall| out_item_t (statistics of one set)
//
// Steps: a sample is inserted into the sorted chain as it is taken. After the
// last sample the chain is rotated once through its MAX_SAMPLES cells (sum and
// median taps), the shared divider forms the mean, the chain is rotated again
// for the squared deviations, the divider forms the variance, and the square
// root then gives the standard deviation for the result.
// Reset: synchronous, active low; clears the count, overflow flag and sequencer.
// Stalls: in_stall stays high from the last sample until the result is placed in
// the output register; a stalled result holds there while the next set loads.
module sample_set_statistics import sss_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int KW     = $clog2(MAX_SAMPLES + 2);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int MEAN_W = SAMPLE_BITS + 1;
  localparam int DIFF_W = SAMPLE_BITS + 2;
  localparam int DVW    = CNT_W + 1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SUM, ST_MSTART, ST_MWAIT, ST_SQ,
    ST_VSTART, ST_VWAIT, ST_RSTART, ST_RWAIT, ST_EMIT
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r;
  logic                 ovf_r;
  logic [KW-1:0]        k_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [MEAN_W-1:0] mean_r;
  sample_t              med_lo_r, med_hi_r, lq_lo_r, lq_hi_r, uq_lo_r, uq_hi_r;
  logic                 a_vld_r, b_vld_r, b_big_r;
  logic [DIFF_W-1:0]    mag_r;
  logic [61:0]          sq_r;
  logic [61:0]          ss_r;
  logic                 ss_sat_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic                 in_fire;
  cell_op_t             cell_op;
  sample_t              cell_val [MAX_SAMPLES];
  logic                 cell_gt  [MAX_SAMPLES];
  sample_t              head;

  // Chain of cells: insert the new sample in order, or rotate toward cell 0.
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    sss_cell u_cell (
      .clk       (clk),
      .op        (cell_op),
      .valid     (CNT_W'(i) < count_r),
      .x         (in_data.sample),
      .left_val  ((i == 0) ? in_data.sample : cell_val[(i == 0) ? 0 : i - 1]),
      .left_gt   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
      .right_val (cell_val[(i + 1) % MAX_SAMPLES]),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  assign head     = cell_val[0];
  assign in_stall = (state_r != ST_LOAD);
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    if (in_fire && (count_r < CNT_W'(MAX_SAMPLES))) begin
      cell_op = CELL_INSERT;
    end else if ((state_r == ST_SUM) ||
                 ((state_r == ST_SQ) && (k_r < KW'(MAX_SAMPLES)))) begin
      cell_op = CELL_ROTATE;
    end else begin
      cell_op = CELL_HOLD;
    end
  end

  // Tap positions for the median and the two half medians.
  logic [CNT_W-1:0] half, med_hi_i, lq_hi_i, uq_hi_i;
  logic             k_in_set;
  assign half     = count_r >> 1;
  assign med_hi_i = half;
  assign lq_hi_i  = half >> 1;
  assign uq_hi_i  = count_r - half + (half >> 1);
  assign k_in_set = k_r < KW'(count_r);

  // Shared divider: mean first, then variance.
  logic [SUM_W-1:0]      sum_mag;
  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] div_dividend, div_q;
  logic [DVW-1:0]        div_divisor;
  logic [MEAN_W-1:0]     mean_mag;

  assign sum_mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign div_start    = (state_r == ST_MSTART) || (state_r == ST_VSTART);
  assign div_dividend = (state_r == ST_MSTART) ?
                        DIVIDEND_W'({sum_mag, 1'b0}) + DIVIDEND_W'(count_r) :
                        {ss_r, 2'b00};
  assign div_divisor  = (state_r == ST_MSTART) ? DVW'({count_r, 1'b0}) :
                        DVW'(count_r - 1'b1);
  assign mean_mag     = MEAN_W'(div_q);

  sss_div #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  logic                  root_done;
  logic [ROOT_OUT_W-1:0] root;

  sss_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_RSTART),
    .radicand (div_q),
    .done     (root_done),
    .root     (root)
  );

  // Squared deviation pipeline: difference, square, accumulate.
  logic signed [DIFF_W-1:0] diff;
  logic [30:0]              mag31;
  logic [61:0]              sq_nxt;
  logic [62:0]              ss_sum;

  assign diff   = DIFF_W'(head) - DIFF_W'(mean_r);
  assign mag31  = 31'(mag_r);
  assign sq_nxt = mag31 * mag31;
  assign ss_sum = {1'b0, ss_r} + {1'b0, sq_r};

  // Result assembly.
  logic [ROOT_OUT_W:0] sd_round;
  logic [23:0]         sd;
  out_item_t           res;

  assign sd_round = ({1'b0, root} + 1'b1) >> 1;

  always_comb begin
    if (count_r <= CNT_W'(1)) begin
      sd = '0;
    end else if (ss_sat_r || (sd_round > (ROOT_OUT_W + 1)'(24'hFFFFFF))) begin
      sd = 24'hFFFFFF;
    end else begin
      sd = sd_round[23:0];
    end
    res.median_value = count_r[0] ? sat_s24(longint'(med_hi_r)) :
                       sat_s24(avg_half(longint'(med_lo_r), longint'(med_hi_r)));
    res.mean_value   = sat_s24(longint'(mean_r));
    res.total        = sat_s32(longint'(sum_r));
    res.std_dev      = sd;
    if (half == '0) begin
      res.lower_quartile = '0;
      res.upper_quartile = '0;
    end else if (half[0]) begin
      res.lower_quartile = sat_s24(longint'(lq_hi_r));
      res.upper_quartile = sat_s24(longint'(uq_hi_r));
    end else begin
      res.lower_quartile = sat_s24(avg_half(longint'(lq_lo_r), longint'(lq_hi_r)));
      res.upper_quartile = sat_s24(avg_half(longint'(uq_lo_r), longint'(uq_hi_r)));
    end
    res.sample_count  = (CNT_W > 9 && count_r > CNT_W'(511)) ? 9'd511 : 9'(count_r);
    res.std_dev_valid = count_r > CNT_W'(1);
    res.overflowed    = ovf_r;
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
    end else begin
      if ((state_r == ST_EMIT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      a_vld_r <= (state_r == ST_SQ) && (k_r < KW'(MAX_SAMPLES)) && k_in_set;
      b_vld_r <= a_vld_r;
      case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (count_r < CNT_W'(MAX_SAMPLES)) begin
              count_r <= count_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_data.last) begin
              state_r <= ST_SUM;
              k_r     <= '0;
            end
          end
        end
        ST_SUM: begin
          k_r <= k_r + 1'b1;
          if (k_r == KW'(MAX_SAMPLES - 1)) begin
            state_r <= ST_MSTART;
          end
        end
        ST_MSTART: state_r <= ST_MWAIT;
        ST_MWAIT: begin
          if (div_done) begin
            state_r <= ST_SQ;
            k_r     <= '0;
          end
        end
        ST_SQ: begin
          k_r <= k_r + 1'b1;
          if (k_r == KW'(MAX_SAMPLES + 1)) begin
            state_r <= ST_VSTART;
          end
        end
        ST_VSTART: state_r <= ST_VWAIT;
        ST_VWAIT: begin
          if (div_done) begin
            state_r <= ST_RSTART;
          end
        end
        ST_RSTART: state_r <= ST_RWAIT;
        ST_RWAIT: begin
          if (root_done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Hand over only once the output register is free.
          if (!out_valid_r || !out_stall) begin
            count_r     <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if ((state_r == ST_LOAD) && in_fire && in_data.last) begin
      sum_r <= '0;
    end else if ((state_r == ST_SUM) && k_in_set) begin
      sum_r <= sum_r + SUM_W'(head);
    end
    if (state_r == ST_SUM) begin
      if (k_r == KW'(med_hi_i))         med_hi_r <= head;
      if (k_r == KW'(med_hi_i - 1'b1))  med_lo_r <= head;
      if (k_r == KW'(lq_hi_i))          lq_hi_r  <= head;
      if (k_r == KW'(lq_hi_i - 1'b1))   lq_lo_r  <= head;
      if (k_r == KW'(uq_hi_i))          uq_hi_r  <= head;
      if (k_r == KW'(uq_hi_i - 1'b1))   uq_lo_r  <= head;
    end
    if ((state_r == ST_MWAIT) && div_done) begin
      mean_r   <= sum_r[SUM_W-1] ? -mean_mag : mean_mag;
      ss_r     <= '0;
      ss_sat_r <= 1'b0;
    end else if (b_vld_r) begin
      if (b_big_r || ss_sum[62]) begin
        ss_sat_r <= 1'b1;
      end else if (!ss_sat_r) begin
        ss_r <= ss_sum[61:0];
      end
    end
    mag_r   <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    sq_r    <= sq_nxt;
    b_big_r <= 64'(mag_r) >= 64'd2147483648;
    if ((state_r == ST_EMIT) && (!out_valid_r || !out_stall)) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/sss_cell.sv =====
// One cell of the sorting chain: holds one sample, inserts or rotates with its neighbors.
module sss_cell import sss_pkg::*; (
  input  logic     clk,
  input  cell_op_t op,
  input  logic     valid,
  input  sample_t  x,
  input  sample_t  left_val,
  input  logic     left_gt,
  input  sample_t  right_val,
  output sample_t  val,
  output logic     gt
);

  sample_t val_r;
  sample_t val_nxt;

  assign val = val_r;
  assign gt  = !valid || (val_r > x);

  always_comb begin
    case (op)
      CELL_INSERT: val_nxt = gt ? (left_gt ? left_val : x) : val_r;
      CELL_ROTATE: val_nxt = right_val;
      default:     val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/sss_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sss_div import sss_pkg::*; #(
  parameter int DVW = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DVW-1:0]        divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_W);

  logic [DVW-1:0]        rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DVW-1:0]        div_r;
  logic [CW-1:0]         cnt_r;
  logic                  run_r;
  logic                  done_r;
  logic [DVW:0]          rem_sh;
  logic                  ge;

  assign rem_sh   = {rem_r, quo_r[DIVIDEND_W-1]};
  assign ge       = rem_sh >= {1'b0, div_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIVIDEND_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? DVW'(rem_sh - {1'b0, div_r}) : DVW'(rem_sh);
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/sss_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
module sss_sqrt import sss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ROOT_IN_W-1:0]  radicand,
  output logic                  done,
  output logic [ROOT_OUT_W-1:0] root
);

  localparam int CW = $clog2(ROOT_OUT_W);
  localparam int RW = ROOT_OUT_W + 3;

  logic [ROOT_IN_W-1:0]  rad_r;
  logic [RW-1:0]         rem_r;
  logic [ROOT_OUT_W-1:0] res_r;
  logic [CW-1:0]         cnt_r;
  logic                  run_r;
  logic                  done_r;
  logic [RW-1:0]         rem_sh;
  logic [RW-1:0]         trial;
  logic                  ge;

  assign rem_sh = {rem_r[RW-3:0], rad_r[ROOT_IN_W-1:ROOT_IN_W-2]};
  assign trial  = {1'b0, res_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign done   = done_r;
  assign root   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ROOT_OUT_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= radicand;
      rem_r <= '0;
      res_r <= '0;
    end else if (run_r) begin
      rad_r <= {rad_r[ROOT_IN_W-3:0], 2'b00};
      rem_r <= ge ? rem_sh - trial : rem_sh;
      res_r <= {res_r[ROOT_OUT_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/sss_checker.sv =====
// Port-level checker for the sample set statistics block, bound to the top level.
module sss_checker import sss_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // Stop taking samples once the set is closed.
  a_close_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("sample taken after last transaction");

  a_dev_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sample_count != 9'd0) &&
                  (out_data.std_dev_valid == (out_data.sample_count > 9'd1)))
    else $error("count and deviation flag disagree");

endmodule

bind sample_set_statistics sss_checker u_sss_checker (.*);
